// ===== rtl/ttip_pkg.sv =====
package ttip_pkg;

   // Field widths
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int CHAR_WIDTH  = 8;
   localparam int BASE_WIDTH  = 6;
   localparam int DIGIT_WIDTH = 5;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_A_UP  = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_F_UP  = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CH_X_UP  = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CH_A_LO  = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_F_LO  = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CH_X_LO  = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CH_TEN   = 8'd10;

   // Bases
   localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

   // Digit value for a character that is not a hex digit
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 5'd31;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_BEGIN  = 6'b000010,
      PH_ZERO   = 6'b000100,
      PH_ZEROX  = 6'b001000,
      PH_HEX0   = 6'b010000,
      PH_DIGITS = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic [BASE_WIDTH-1:0] num_base;
      logic                  signed_mode;
      logic                  first_char;
      logic                  end_of_string;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [COUNT_WIDTH-1:0] consumed_count;
      logic [BASE_WIDTH-1:0]  base_used;
   } rsp_type;

   typedef struct packed {
      phase_type              phase;
      logic [VALUE_WIDTH-1:0] acc;
      logic [BASE_WIDTH-1:0]  base;
      logic [COUNT_WIDTH-1:0] cnt;
      logic                   neg;
   } parse_state_type;

   // Hex digit value, DIGIT_NONE for anything else
   function automatic logic [DIGIT_WIDTH-1:0] hex_digit(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0]  d;
      logic [DIGIT_WIDTH-1:0] r;
      d = '0;
      r = DIGIT_NONE;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         r = d[DIGIT_WIDTH-1:0];
      end else if (c >= CH_A_UP && c <= CH_F_UP) begin
         d = c - CH_A_UP + CH_TEN;
         r = d[DIGIT_WIDTH-1:0];
      end else if (c >= CH_A_LO && c <= CH_F_LO) begin
         d = c - CH_A_LO + CH_TEN;
         r = d[DIGIT_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic is_x(input logic [CHAR_WIDTH-1:0] c);
      return (c == CH_X_UP) || (c == CH_X_LO);
   endfunction

   // Saturating count increment by one or two
   function automatic logic [COUNT_WIDTH-1:0] count_add(input logic [COUNT_WIDTH-1:0] cnt,
                                                        input logic [1:0] n);
      logic [COUNT_WIDTH:0] t;
      t = {1'b0, cnt} + (COUNT_WIDTH + 1)'(n);
      return t[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : t[COUNT_WIDTH-1:0];
   endfunction

   // Result fields from the parser state at the stop position
   function automatic rsp_type make_rsp(input parse_state_type st);
      rsp_type r;
      r.value          = st.neg ? (VALUE_WIDTH'(0) - st.acc) : st.acc;
      r.consumed_count = st.cnt;
      r.base_used      = st.base;
      return r;
   endfunction

endpackage

// ===== rtl/text_to_integer_parser.sv =====
// Channel | Ports                            | Transaction
// --------+----------------------------------+----------------------------------------
// request | req_valid, req_stall, req_data   | one character with string markers
// result  | rsp_valid, rsp_stall, rsp_data   | parsed value, consumed count, base used
//
// One character is accepted per cycle unless the result is stalled; a result is registered
// after the input register. The per-character path is one 32x6 multiply-add plus the prefix
// decode, between the input register and the parser state / result registers.
// Reset clears the valid flags and returns the parser to idle.
// A stalled result freezes both stages; the request side sees stall in the same cycle.
module text_to_integer_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ttip_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ttip_pkg::rsp_type rsp_data
);
   import ttip_pkg::*;

   logic            advance;
   logic            in_valid_ff;
   req_type         in_data_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            emit;
   rsp_type         result;
   logic            out_valid_ff;
   rsp_type         out_data_ff;

   // Pipeline moves unless a result is waiting and stalled
   assign advance   = ~(out_valid_ff & rsp_stall);
   assign req_stall = ~advance;

   ttip_step u_step (
      .cur_state  (state_ff),
      .item       (in_data_ff),
      .next_state (state_in),
      .emit       (emit),
      .result     (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= PH_IDLE;
         state_ff.acc   <= '0;
         state_ff.base  <= '0;
         state_ff.cnt   <= '0;
         state_ff.neg   <= 1'b0;
      end else if (advance && in_valid_ff) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff & emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/ttip_step.sv =====
module ttip_step (
   input  ttip_pkg::parse_state_type cur_state,
   input  ttip_pkg::req_type         item,
   output ttip_pkg::parse_state_type next_state,
   output logic                      emit,
   output ttip_pkg::rsp_type         result
);
   import ttip_pkg::*;

   parse_state_type                     st0;
   parse_state_type                     st1;
   parse_state_type                     st2;
   logic                                take_minus;
   logic                                fall;
   logic                                emit1;
   logic                                fin;
   logic [DIGIT_WIDTH-1:0]              digit;
   logic                                digit_ok;
   logic [VALUE_WIDTH+BASE_WIDTH-1:0]   prod;
   logic [VALUE_WIDTH-1:0]              mac;

   assign digit      = hex_digit(item.char_code);
   assign take_minus = item.first_char & item.signed_mode & (item.char_code == CH_MINUS);

   // Start of string: fresh state, optional leading minus
   always_comb begin
      st0 = cur_state;
      if (item.first_char) begin
         st0.phase = PH_BEGIN;
         st0.acc   = '0;
         st0.base  = item.num_base;
         st0.cnt   = '0;
         st0.neg   = 1'b0;
         if (take_minus) begin
            st0.neg = 1'b1;
            st0.cnt = count_add('0, 2'd1);
         end
      end
   end

   // Prefix handling, then at most one digit step
   always_comb begin
      st1   = st0;
      fall  = 1'b0;
      emit1 = 1'b0;
      if (!take_minus) begin
         unique case (st0.phase)
            PH_IDLE: begin
            end
            PH_BEGIN: begin
               if (st0.base == BASE_AUTO) begin
                  if (item.char_code == CH_ZERO) begin
                     st1.cnt   = count_add(st0.cnt, 2'd1);
                     st1.base  = BASE_OCT;
                     st1.phase = PH_ZERO;
                  end else begin
                     st1.base = BASE_DEC;
                     fall     = 1'b1;
                  end
               end else if (st0.base == BASE_HEX && item.char_code == CH_ZERO) begin
                  st1.phase = PH_HEX0;
               end else begin
                  fall = 1'b1;
               end
            end
            PH_ZERO: begin
               if (is_x(item.char_code)) begin
                  st1.phase = PH_ZEROX;
               end else begin
                  fall = 1'b1;
               end
            end
            PH_ZEROX: begin
               if (digit != DIGIT_NONE) begin
                  st1.base  = BASE_HEX;
                  st1.cnt   = count_add(st0.cnt, 2'd2);
                  st1.acc   = VALUE_WIDTH'(digit);
                  st1.phase = PH_DIGITS;
               end else begin
                  emit1 = 1'b1;
               end
            end
            PH_HEX0: begin
               if (is_x(item.char_code)) begin
                  st1.cnt   = count_add(st0.cnt, 2'd2);
                  st1.phase = PH_DIGITS;
               end else begin
                  st1.cnt = count_add(st0.cnt, 2'd1);
                  fall    = 1'b1;
               end
            end
            PH_DIGITS: begin
               fall = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Digit step: acc * base + digit; non-hex characters never count, whatever the base
      prod     = st1.acc * st1.base;
      mac      = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit);
      digit_ok = (digit != DIGIT_NONE) && ({1'b0, digit} < st1.base);
      if (fall) begin
         st1.phase = PH_DIGITS;
         if (digit_ok) begin
            st1.acc = mac;
            st1.cnt = count_add(st1.cnt, 2'd1);
         end else begin
            emit1 = 1'b1;
         end
      end
   end

   // End of string acts as a trailing stop character
   assign fin = item.end_of_string & ~emit1 & (st1.phase != PH_IDLE);

   always_comb begin
      st2 = st1;
      if (fin) begin
         if (st1.phase == PH_BEGIN && st1.base == BASE_AUTO) begin
            st2.base = BASE_DEC;
         end
         if (st1.phase == PH_HEX0) begin
            st2.cnt = count_add(st1.cnt, 2'd1);
         end
      end
   end

   // Result and next state
   always_comb begin
      emit   = emit1 | fin;
      result = emit1 ? make_rsp(st1) : make_rsp(st2);
      next_state = st2;
      if (emit) begin
         next_state.phase = PH_IDLE;
      end
   end

endmodule

// ===== rtl/ttip_checker.sv =====
module ttip_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ttip_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ttip_pkg::rsp_type rsp_data
);
   import ttip_pkg::*;

   logic req_seen;
   assign req_seen = req_valid & (req_data.first_char | ~req_data.first_char);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // Automatic base detection always resolves to a real base
   a_base_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.base_used != BASE_AUTO)
      else $error("result reports base zero");

   // A new result traces back to an accepted transaction, through the input and result registers
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_seen && !req_stall, 2))
      else $error("result without a preceding transaction");

   // Nothing is offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
